>>> sv/assert_macros.svh
// assertion macros used by the top-level rtl file
// no dependencies; expects clk and rst_n in the including scope
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold at every clock edge out of reset
`define CHK_ALWAYS(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("check failed");

// same-cycle implication
`define CHK_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("check failed");

`endif

>>> sv/srg_pkg.sv
// types, constants and index helpers for the subtractive random generator
// no dependencies
package srg_pkg;

  typedef logic [31:0] word_t;
  typedef logic [5:0]  idx_t;
  typedef logic [1:0]  cmd_t;
  typedef logic [1:0]  pass_t;

  // lag table geometry
  localparam idx_t  LAST_IDX          = 6'd54;
  localparam idx_t  SCATTER_STEP      = 6'd21;
  localparam idx_t  MIX_PARTNER_START = 6'd31;
  localparam idx_t  TRAIL_START       = 6'd31;
  localparam pass_t LAST_PASS         = 2'd3;
  localparam word_t SEED_DEFAULT      = 32'hdeadbeef;
  localparam logic [6:0] TABLE_LEN    = 7'd55;

  // command codes
  localparam cmd_t CMD_PLAIN = 2'd0;
  localparam cmd_t CMD_MAX   = 2'd1;
  localparam cmd_t CMD_RANGE = 2'd2;
  localparam cmd_t CMD_SPARE = 2'd3;

  // difference and bound test from the shared unit
  typedef struct packed {
    word_t diff;
    logic  pass;
  } srg_res_t;

  // sum of two table indexes, wrapped into the table
  function automatic idx_t idx_add(idx_t a, idx_t b);
    logic [6:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= TABLE_LEN) begin
      s = s - TABLE_LEN;
    end
    return s[5:0];
  endfunction

  // next table index, wrapped
  function automatic idx_t idx_inc(idx_t a);
    return (a == LAST_IDX) ? 6'd0 : a + 6'd1;
  endfunction

endpackage

>>> sv/subtractive_random_generator.sv
// top level: lag table, seeding and draw sequencer of the subtractive generator
// depends on srg_pkg, srg_alu and assert_macros.svh
//
//  channel  ports                                   handshake
//  in       in_cmd, in_bound_low, in_bound_high     start & !busy
//  out      out_value, out_gave_up                  out_strobe, one cycle
//  cfg      cfg_wdata                               cfg_we, no wait
//
// a draw is a table read, then a subtract and write back; a plain item takes
// one draw, a bounded item one per try, at most MAX_TRIES draws. after reset
// and after each seed write the table is seeded (a seed write, 54 scatter
// writes, 4 passes of 55 read/write pairs), busy high meanwhile. the result
// strobe is registered and rises in the cycle after the last write; busy drops
// with it. the receiver cannot stall; the single table port pair sets the pace.
`include "assert_macros.svh"

module subtractive_random_generator #(
  parameter int MAX_TRIES = 64
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  srg_pkg::cmd_t        in_cmd,
  input  srg_pkg::word_t       in_bound_low,
  input  srg_pkg::word_t       in_bound_high,
  output logic                 out_strobe,
  output srg_pkg::word_t       out_value,
  output logic                 out_gave_up,
  input  logic                 cfg_we,
  input  srg_pkg::word_t       cfg_wdata
);

  localparam int TW = $clog2(MAX_TRIES + 1);

  localparam logic [2:0] ST_SEED0  = 3'd0;
  localparam logic [2:0] ST_SCAT   = 3'd1;
  localparam logic [2:0] ST_MIXRD  = 3'd2;
  localparam logic [2:0] ST_MIXWR  = 3'd3;
  localparam logic [2:0] ST_IDLE   = 3'd4;
  localparam logic [2:0] ST_DRAWRD = 3'd5;
  localparam logic [2:0] ST_DRAWWR = 3'd6;

  logic [2:0]          state_r, state_nxt;
  srg_pkg::word_t      seed_r, seed_nxt;
  srg_pkg::idx_t       lead_r, lead_nxt;
  srg_pkg::idx_t       trail_r, trail_nxt;
  logic                pend_r, pend_nxt;
  logic                out_strobe_r, out_strobe_nxt;

  srg_pkg::word_t      s_r, s_nxt;
  srg_pkg::word_t      k_r, k_nxt;
  srg_pkg::idx_t       p_r, p_nxt;
  srg_pkg::idx_t       i_r, i_nxt;
  srg_pkg::idx_t       j_r, j_nxt;
  srg_pkg::pass_t      pass_r, pass_nxt;
  logic [TW-1:0]       tries_r, tries_nxt;
  srg_pkg::cmd_t       cmd_r, cmd_nxt;
  srg_pkg::word_t      lo_r, lo_nxt;
  srg_pkg::word_t      hi_r, hi_nxt;
  srg_pkg::word_t      out_value_r, out_value_nxt;
  logic                out_gave_up_r, out_gave_up_nxt;

  srg_pkg::word_t      lag_mem [55];
  srg_pkg::word_t      rd_a_r, rd_b_r;
  logic                mem_we;
  srg_pkg::idx_t       mem_wa, mem_ra, mem_rb;
  srg_pkg::word_t      mem_wd;

  srg_pkg::word_t      op_a, op_b;
  srg_pkg::srg_res_t   res;

  // shared subtract and bound test
  srg_alu u_alu (
    .op_a       (op_a),
    .op_b       (op_b),
    .cmd        (cmd_r),
    .bound_low  (lo_r),
    .bound_high (hi_r),
    .res        (res)
  );

  // lag table: one write, two registered reads
  always_ff @(posedge clk) begin
    if (mem_we) begin
      lag_mem[mem_wa] <= mem_wd;
    end
    rd_a_r <= lag_mem[mem_ra];
    rd_b_r <= lag_mem[mem_rb];
  end

  // sequencer
  always_comb begin
    state_nxt       = state_r;
    seed_nxt        = seed_r;
    lead_nxt        = lead_r;
    trail_nxt       = trail_r;
    pend_nxt        = pend_r;
    out_strobe_nxt  = 1'b0;
    s_nxt           = s_r;
    k_nxt           = k_r;
    p_nxt           = p_r;
    i_nxt           = i_r;
    j_nxt           = j_r;
    pass_nxt        = pass_r;
    tries_nxt       = tries_r;
    cmd_nxt         = cmd_r;
    lo_nxt          = lo_r;
    hi_nxt          = hi_r;
    out_value_nxt   = out_value_r;
    out_gave_up_nxt = out_gave_up_r;
    mem_we          = 1'b0;
    mem_wa          = i_r;
    mem_wd          = res.diff;
    mem_ra          = srg_pkg::idx_inc(lead_r);
    mem_rb          = srg_pkg::idx_inc(trail_r);
    op_a            = rd_a_r;
    op_b            = rd_b_r;

    unique case (state_r)
      // seed goes to the last entry
      ST_SEED0: begin
        mem_we    = 1'b1;
        mem_wa    = srg_pkg::LAST_IDX;
        mem_wd    = seed_r;
        s_nxt     = seed_r;
        k_nxt     = 32'd1;
        p_nxt     = srg_pkg::SCATTER_STEP;
        i_nxt     = 6'd0;
        state_nxt = ST_SCAT;
      end
      // scatter the subtractive sequence 21 apart
      ST_SCAT: begin
        op_a   = s_r;
        op_b   = k_r;
        mem_we = 1'b1;
        mem_wa = p_r - 6'd1;
        mem_wd = k_r;
        k_nxt  = res.diff;
        s_nxt  = k_r;
        p_nxt  = srg_pkg::idx_add(p_r, srg_pkg::SCATTER_STEP);
        i_nxt  = i_r + 6'd1;
        if (i_r == srg_pkg::LAST_IDX - 6'd1) begin
          i_nxt     = 6'd0;
          j_nxt     = srg_pkg::MIX_PARTNER_START;
          pass_nxt  = 2'd0;
          state_nxt = ST_MIXRD;
        end
      end
      // mixing pass: read entry and its partner
      ST_MIXRD: begin
        mem_ra    = i_r;
        mem_rb    = j_r;
        state_nxt = ST_MIXWR;
      end
      // mixing pass: subtract and write back
      ST_MIXWR: begin
        mem_we    = 1'b1;
        mem_wa    = i_r;
        i_nxt     = srg_pkg::idx_inc(i_r);
        j_nxt     = srg_pkg::idx_inc(j_r);
        state_nxt = ST_MIXRD;
        if (i_r == srg_pkg::LAST_IDX) begin
          pass_nxt = pass_r + 2'd1;
          if (pass_r == srg_pkg::LAST_PASS) begin
            lead_nxt  = 6'd0;
            trail_nxt = srg_pkg::TRAIL_START;
            pend_nxt  = 1'b0;
            state_nxt = pend_r ? ST_DRAWRD : ST_IDLE;
          end
        end
      end
      // accept an item; table reads for the first draw go out now
      ST_IDLE: begin
        if (start) begin
          cmd_nxt   = in_cmd;
          lo_nxt    = in_bound_low;
          hi_nxt    = in_bound_high;
          tries_nxt = '0;
          lead_nxt  = srg_pkg::idx_inc(lead_r);
          trail_nxt = srg_pkg::idx_inc(trail_r);
          state_nxt = ST_DRAWWR;
        end
      end
      // advance pointers and read for a draw
      ST_DRAWRD: begin
        lead_nxt  = srg_pkg::idx_inc(lead_r);
        trail_nxt = srg_pkg::idx_inc(trail_r);
        state_nxt = ST_DRAWWR;
      end
      // write back the draw, then deliver or draw again
      ST_DRAWWR: begin
        mem_we = 1'b1;
        mem_wa = lead_r;
        if (res.pass || (tries_r == TW'(MAX_TRIES - 1))) begin
          out_strobe_nxt  = 1'b1;
          out_value_nxt   = res.diff;
          out_gave_up_nxt = !res.pass;
          state_nxt       = ST_IDLE;
        end else begin
          tries_nxt = tries_r + TW'(1);
          state_nxt = ST_DRAWRD;
        end
      end
      default: begin
        state_nxt = ST_SEED0;
      end
    endcase

    // seed write restarts seeding; an item taken in the same cycle waits for it
    if (cfg_we) begin
      seed_nxt  = cfg_wdata;
      state_nxt = ST_SEED0;
      if ((state_r == ST_IDLE) && start) begin
        pend_nxt = 1'b1;
      end
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_SEED0;
      seed_r       <= srg_pkg::SEED_DEFAULT;
      lead_r       <= 6'd0;
      trail_r      <= srg_pkg::TRAIL_START;
      pend_r       <= 1'b0;
      out_strobe_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      seed_r       <= seed_nxt;
      lead_r       <= lead_nxt;
      trail_r      <= trail_nxt;
      pend_r       <= pend_nxt;
      out_strobe_r <= out_strobe_nxt;
    end
  end

  // working and payload registers
  always_ff @(posedge clk) begin
    s_r           <= s_nxt;
    k_r           <= k_nxt;
    p_r           <= p_nxt;
    i_r           <= i_nxt;
    j_r           <= j_nxt;
    pass_r        <= pass_nxt;
    tries_r       <= tries_nxt;
    cmd_r         <= cmd_nxt;
    lo_r          <= lo_nxt;
    hi_r          <= hi_nxt;
    out_value_r   <= out_value_nxt;
    out_gave_up_r <= out_gave_up_nxt;
  end

  // ports
  assign busy        = (state_r != ST_IDLE);
  assign out_strobe  = out_strobe_r;
  assign out_value   = out_value_r;
  assign out_gave_up = out_gave_up_r;

  // checks
  `CHK_ALWAYS(a_lead_in_range, lead_r <= srg_pkg::LAST_IDX)
  `CHK_ALWAYS(a_ptr_offset, trail_r == srg_pkg::idx_add(lead_r, srg_pkg::TRAIL_START))
  `CHK_IMP(a_strobe_after_draw, out_strobe, $past(state_r) == ST_DRAWWR)
  `CHK_IMP(a_gave_up_bounded, out_strobe && out_gave_up, (cmd_r == srg_pkg::CMD_MAX) || (cmd_r == srg_pkg::CMD_RANGE))

endmodule

>>> sv/srg_alu.sv
// shared wrapping subtractor with the bound test of the current command
// depends on srg_pkg
module srg_alu (
  input  srg_pkg::word_t    op_a,
  input  srg_pkg::word_t    op_b,
  input  srg_pkg::cmd_t     cmd,
  input  srg_pkg::word_t    bound_low,
  input  srg_pkg::word_t    bound_high,
  output srg_pkg::srg_res_t res
);

  srg_pkg::word_t diff;

  // wrapping subtract
  assign diff = op_a - op_b;

  // bound test; plain and spare codes always pass
  always_comb begin
    res.diff = diff;
    unique case (cmd)
      srg_pkg::CMD_MAX:   res.pass = (diff <= bound_high);
      srg_pkg::CMD_RANGE: res.pass = (diff > bound_low) && (diff <= bound_high);
      srg_pkg::CMD_PLAIN,
      srg_pkg::CMD_SPARE: res.pass = 1'b1;
      default:            res.pass = 1'b1;
    endcase
  end

endmodule

>>> bench/tb.sv
// self-checking bench for subtractive_random_generator: directed and random draw requests
// with a cycle-free predictor of the lag table; depends on srg_pkg and the rtl under sv/
module tb;

  localparam int TRY_LIMIT   = 64;
  localparam int LAG_LEN     = 55;
  localparam int SCATTER     = 21;
  localparam int MIX_SHIFT   = 31;
  localparam int MIX_ROUNDS  = 4;
  localparam int RANDOM_ITEMS = 1900;
  localparam int SEED_PHASES = 4;
  localparam int DRAIN_CYCLES = 2 * TRY_LIMIT + 8;
  localparam longint RUN_LIMIT = 64'd30_000_000;

  typedef struct packed {
    srg_pkg::word_t value;
    logic           gave_up;
  } draw_t;

  logic           clk = 1'b0;
  logic           rst_n = 1'b0;
  logic           start = 1'b0;
  logic           busy;
  srg_pkg::cmd_t  in_cmd = srg_pkg::CMD_PLAIN;
  srg_pkg::word_t in_bound_low = '0;
  srg_pkg::word_t in_bound_high = '0;
  logic           out_strobe;
  srg_pkg::word_t out_value;
  logic           out_gave_up;
  logic           cfg_we = 1'b0;
  srg_pkg::word_t cfg_wdata = '0;

  // predicted generator state
  srg_pkg::word_t lag_words [LAG_LEN];
  int             lead_pos;
  int             trail_pos;
  logic           reseed_due;
  srg_pkg::word_t seed_reg;

  draw_t pending_draws [$];
  int    fail_count = 0;

  subtractive_random_generator #(.MAX_TRIES(TRY_LIMIT)) dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .in_cmd       (in_cmd),
    .in_bound_low (in_bound_low),
    .in_bound_high(in_bound_high),
    .out_strobe   (out_strobe),
    .out_value    (out_value),
    .out_gave_up  (out_gave_up),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata)
  );

  // clock
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // scatter the seed sequence, then mix the table
  function automatic void seed_lag_table(srg_pkg::word_t s);
    srg_pkg::word_t k;
    int             pos;
    k = 32'd1;
    lag_words[LAG_LEN - 1] = s;
    for (int i = 0; i < LAG_LEN - 1; i++) begin
      pos = ((SCATTER * (i + 1)) % LAG_LEN) - 1;
      lag_words[pos] = k;
      k = s - k;
      s = lag_words[pos];
    end
    for (int p = 0; p < MIX_ROUNDS; p++) begin
      for (int i = 0; i < LAG_LEN; i++) begin
        lag_words[i] = lag_words[i] - lag_words[(i + MIX_SHIFT) % LAG_LEN];
      end
    end
    lead_pos = 0;
    trail_pos = int'(srg_pkg::TRAIL_START);
    reseed_due = 1'b0;
  endfunction

  // one subtractive step of the lagged sequence
  function automatic srg_pkg::word_t next_word();
    lead_pos = (lead_pos + 1) % LAG_LEN;
    trail_pos = (trail_pos + 1) % LAG_LEN;
    lag_words[lead_pos] = lag_words[lead_pos] - lag_words[trail_pos];
    return lag_words[lead_pos];
  endfunction

  // expected result of one request, with rejection and give-up
  function automatic draw_t predict_draw(srg_pkg::cmd_t c, srg_pkg::word_t lo,
                                         srg_pkg::word_t hi);
    draw_t d;
    logic  ok;
    int    n;
    if (reseed_due) begin
      seed_lag_table(seed_reg);
    end
    d.value = '0;
    d.gave_up = 1'b0;
    if (c == srg_pkg::CMD_MAX || c == srg_pkg::CMD_RANGE) begin
      ok = 1'b0;
      n = 0;
      while (n < TRY_LIMIT && !ok) begin
        d.value = next_word();
        ok = (c == srg_pkg::CMD_MAX) ? (d.value <= hi)
                                     : (d.value > lo && d.value <= hi);
        n++;
      end
      d.gave_up = !ok;
    end else begin
      d.value = next_word();
    end
    return d;
  endfunction

  // result checker
  always @(posedge clk) begin
    draw_t want;
    if (rst_n && out_strobe) begin
      if (pending_draws.size() == 0) begin
        fail_count++;
        if (fail_count <= 10) begin
          $display("tb: result with nothing pending: value %h gave_up %b",
                   out_value, out_gave_up);
        end
      end else begin
        want = pending_draws.pop_front();
        if (out_value !== want.value || out_gave_up !== want.gave_up) begin
          fail_count++;
          if (fail_count <= 10) begin
            $display("tb: mismatch: value exp %h got %h, gave_up exp %b got %b",
                     want.value, out_value, want.gave_up, out_gave_up);
          end
        end
      end
    end
  end

  // present one item and hold it until the block takes it; start stays high
  task automatic send_item(srg_pkg::cmd_t c, srg_pkg::word_t lo, srg_pkg::word_t hi);
    start <= 1'b1;
    in_cmd <= c;
    in_bound_low <= lo;
    in_bound_high <= hi;
    do begin
      @(posedge clk);
    end while (!(start && !busy));
    pending_draws.push_back(predict_draw(c, lo, hi));
  endtask

  // sender gap
  task automatic idle_cycles(int n);
    start <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  // seed write once every item has come back
  task automatic write_seed(srg_pkg::word_t s);
    start <= 1'b0;
    while (pending_draws.size() != 0) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= s;
    @(posedge clk);
    cfg_we <= 1'b0;
    cfg_wdata <= $urandom;
    seed_reg = s;
    reseed_due = 1'b1;
    // seeding must have started before the next item goes out
    while (!busy) @(posedge clk);
  endtask

  // draws straight after reset with the default seed, spare command included
  task automatic test_default_seed();
    send_item(srg_pkg::CMD_PLAIN, 32'h0, 32'h0);
    send_item(srg_pkg::CMD_PLAIN, 32'hffff_ffff, 32'hffff_ffff);
    send_item(srg_pkg::CMD_SPARE, 32'h0, 32'h0);
    idle_cycles(3);
    send_item(srg_pkg::CMD_SPARE, 32'hffff_ffff, 32'h1234_5678);
  endtask

  // bound edges: never-pass, always-pass and empty ranges
  task automatic test_bound_edges();
    send_item(srg_pkg::CMD_MAX, 32'h0, 32'h0);
    send_item(srg_pkg::CMD_MAX, 32'h0, 32'hffff_ffff);
    send_item(srg_pkg::CMD_MAX, 32'hffff_ffff, 32'h7fff_ffff);
    send_item(srg_pkg::CMD_RANGE, 32'h0, 32'hffff_ffff);
    send_item(srg_pkg::CMD_RANGE, 32'h0000_0005, 32'h0000_0005);
    idle_cycles(1);
    send_item(srg_pkg::CMD_RANGE, 32'hffff_ffff, 32'h0);
    send_item(srg_pkg::CMD_RANGE, 32'h8000_0000, 32'hffff_ffff);
    send_item(srg_pkg::CMD_RANGE, 32'hffff_fffe, 32'hffff_ffff);
    send_item(srg_pkg::CMD_RANGE, 32'h4000_0000, 32'hc000_0000);
    send_item(srg_pkg::CMD_MAX, 32'h0, 32'h0000_00ff);
  endtask

  // extreme seeds and then the default seed, each followed by a few requests
  task automatic test_seed_extremes();
    write_seed(32'h0);
    send_item(srg_pkg::CMD_PLAIN, 32'h0, 32'h0);
    send_item(srg_pkg::CMD_MAX, 32'h0, 32'h8000_0000);
    send_item(srg_pkg::CMD_RANGE, 32'h1000_0000, 32'hf000_0000);
    write_seed(32'hffff_ffff);
    send_item(srg_pkg::CMD_PLAIN, 32'h0, 32'h0);
    send_item(srg_pkg::CMD_MAX, 32'h0, 32'hffff_fffe);
    write_seed(srg_pkg::SEED_DEFAULT);
    send_item(srg_pkg::CMD_RANGE, 32'h0, 32'h0000_0001);
    send_item(srg_pkg::CMD_PLAIN, 32'h0, 32'h0);
  endtask

  // random requests in bursts, reseeding between phases
  task automatic test_random_traffic();
    int             burst;
    int             pick;
    srg_pkg::cmd_t  c;
    srg_pkg::word_t lo;
    srg_pkg::word_t hi;
    srg_pkg::word_t span;
    burst = $urandom_range(20, 1);
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n > 0 && n % (RANDOM_ITEMS / SEED_PHASES) == 0) begin
        write_seed($urandom);
      end
      pick = $urandom_range(99);
      lo = $urandom;
      hi = $urandom;
      if (pick < 25) begin
        c = (pick < 6) ? srg_pkg::CMD_SPARE : srg_pkg::CMD_PLAIN;
      end else if (pick < 55) begin
        c = srg_pkg::CMD_MAX;
        // mostly reachable bounds, now and then a tiny one
        if (pick < 29) begin
          hi = $urandom_range(255);
        end
      end else if (pick < 90) begin
        c = srg_pkg::CMD_RANGE;
        span = $urandom >> $urandom_range(3);
        hi = lo + span;
        if (hi < lo) begin
          hi = 32'hffff_ffff;
        end
      end else begin
        // unordered bounds, often an empty range
        c = srg_pkg::CMD_RANGE;
      end
      send_item(c, lo, hi);
      burst--;
      if (burst == 0) begin
        // long bursts now and then give stretches with no gaps
        burst = ($urandom_range(7) == 0) ? $urandom_range(80, 30) : $urandom_range(20, 1);
        idle_cycles($urandom_range(12, 1));
      end
    end
  endtask

  // main sequence
  initial begin
    seed_reg = srg_pkg::SEED_DEFAULT;
    reseed_due = 1'b1;
    lead_pos = 0;
    trail_pos = int'(srg_pkg::TRAIL_START);
    for (int i = 0; i < LAG_LEN; i++) begin
      lag_words[i] = '0;
    end
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_default_seed();
    test_bound_edges();
    test_seed_extremes();
    test_random_traffic();
    start <= 1'b0;
    while (pending_draws.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending_draws.size() == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

  // run limit
  initial begin
    #(RUN_LIMIT);
    $display("tb: done, errors");
    $finish;
  end

endmodule

>>> sim.f
+incdir+sv
sv/srg_pkg.sv
sv/srg_alu.sv
sv/subtractive_random_generator.sv
bench/tb.sv
